>>> rtl/core/qrm_pkg.sv
// Package for the quaternion to rotation matrix unit.
// Holds the queue item and status types shared by the front, queue and back.
package qrm_pkg;

    localparam int ENTRIES     = 9;
    localparam int NORM_W      = 33;
    localparam int REM_W       = 34;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [NORM_W-1:0]              norm;
        logic [ENTRIES-1:0][NORM_W-1:0] mag;
        logic [ENTRIES-1:0]             sgn;
        logic                           degen;
    } qrm_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qrm_qstat_t;

endpackage

>>> rtl/core/quaternion_to_rotation_matrix_unit.sv
// Quaternion to 3x3 rotation matrix unit, top level.
// Depends on qrm_pkg, qrm_front, qrm_queue and qrm_back.
//
//  channel  dir  fields (tdata low bit up)                 tuser
//  s_       in   quat_x quat_y quat_z quat_w (4 x 16)       -
//  m_       out  m00 m01 m02 m10 m11 m12 m20 m21 m22 (16)   degenerate
//
// One quaternion per cycle sustained while m_tready stays high. The path runs through
// two front stages (products, sums), one queue slot, FRAC_BITS + 2
// divider stages (one quotient bit each) and the output register.
// Reset is synchronous, active low; no clearing pass.
// The back stalls as a whole on m_tready; the four-entry queue lets the
// front keep accepting until it fills.
module quaternion_to_rotation_matrix_unit import qrm_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic         m_tuser    // degenerate
);

    qrm_qstat_t stat;
    qrm_item_t  push_item, head;
    logic       push, pop;

    qrm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .stat      (stat),
        .push      (push),
        .push_item (push_item)
    );

    qrm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    qrm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .stat      (stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_degen (m_tuser)
    );

`ifndef SYNTHESIS
    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.full && stat.empty)) else $error("queue full and empty");
    a_degen_offdiag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:16] == 16'd0 && m_tdata[111:96] == 16'd0)
        else $error("degenerate result with nonzero off-diagonal");
    a_degen_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[15:0] == m_tdata[79:64]
        && m_tdata[79:64] == m_tdata[143:128])
        else $error("degenerate result with unequal diagonal");
`endif

endmodule

>>> rtl/core/qrm_front.sv
// Front part: squares and cross products, then norm and entry numerators.
// Depends on qrm_pkg.
module qrm_front import qrm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] in_data,
    input  qrm_qstat_t  stat,
    output logic        push,
    output qrm_item_t   push_item
);

    logic v1_reg, v2_reg, adv;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0] xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;
    logic zero_reg;
    qrm_item_t item_reg;
    logic signed [15:0] qx, qy, qz, qw;
    logic signed [33:0] nn, e [ENTRIES];
    qrm_item_t item_next;

    assign qx = in_data[15:0];
    assign qy = in_data[31:16];
    assign qz = in_data[47:32];
    assign qw = in_data[63:48];

    assign adv       = !v2_reg || !stat.full;
    assign in_ready  = adv;
    assign push      = v2_reg && !stat.full;
    assign push_item = item_reg;

    always_comb begin
        nn = 34'(xx_reg) + 34'(yy_reg) + 34'(zz_reg) + 34'(ww_reg);
        e[0] = nn - 34'(yy_reg) * 2 - 34'(zz_reg) * 2;
        e[1] = (34'(xy_reg) + 34'(zw_reg)) * 2;
        e[2] = (34'(xz_reg) - 34'(yw_reg)) * 2;
        e[3] = (34'(xy_reg) - 34'(zw_reg)) * 2;
        e[4] = nn - 34'(xx_reg) * 2 - 34'(zz_reg) * 2;
        e[5] = (34'(yz_reg) + 34'(xw_reg)) * 2;
        e[6] = (34'(xz_reg) + 34'(yw_reg)) * 2;
        e[7] = (34'(yz_reg) - 34'(xw_reg)) * 2;
        e[8] = nn - 34'(xx_reg) * 2 - 34'(yy_reg) * 2;
        item_next.norm  = nn[NORM_W-1:0];
        item_next.degen = zero_reg;
        for (int i = 0; i < ENTRIES; i++) begin
            item_next.sgn[i] = e[i][33];
            item_next.mag[i] = e[i][33] ? NORM_W'(-e[i]) : e[i][NORM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            xx_reg   <= qx * qx;
            yy_reg   <= qy * qy;
            zz_reg   <= qz * qz;
            ww_reg   <= qw * qw;
            xy_reg   <= qx * qy;
            zw_reg   <= qz * qw;
            xz_reg   <= qx * qz;
            yw_reg   <= qy * qw;
            yz_reg   <= qy * qz;
            xw_reg   <= qx * qw;
            zero_reg <= (in_data == 64'd0);
            item_reg <= item_next;
        end
    end

endmodule

>>> rtl/core/qrm_queue.sv
// Short queue between the front and back parts.
// Depends on qrm_pkg.
module qrm_queue import qrm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  qrm_item_t  push_item,
    input  logic       pop,
    output qrm_item_t  head,
    output qrm_qstat_t stat
);

    qrm_item_t mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0] cnt_reg;
    logic do_push, do_pop;

    assign stat.full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wp_reg <= wp_reg + 1'b1;
            if (do_pop)  rp_reg <= rp_reg + 1'b1;
            if (do_push && !do_pop) cnt_reg <= cnt_reg + 1'b1;
            else if (!do_push && do_pop) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wp_reg] <= push_item;
    end

endmodule

>>> rtl/core/qrm_back.sv
// Back part: nine pipelined restoring dividers, one quotient bit per stage,
// then rounding, clamping and the output register. Depends on qrm_pkg.
module qrm_back import qrm_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  qrm_item_t    head,
    input  qrm_qstat_t   stat,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [143:0] out_data,
    output logic         out_degen
);

    localparam int QW = FRAC_BITS + 2;
    localparam int D  = FRAC_BITS + 2;
    localparam int SW = (QW + 1 > 17) ? QW + 1 : 17;

    logic adv;
    logic               v_reg   [D];
    logic [NORM_W-1:0]  n_reg   [D];
    logic [ENTRIES-1:0] sgn_reg [D];
    logic               dg_reg  [D];
    logic [REM_W-1:0]   rem_reg [D][ENTRIES];
    logic [QW-1:0]      quo_reg [D][ENTRIES];
    logic               ov_reg;
    logic [143:0]       od_reg;
    logic               odg_reg;
    logic [143:0]       od_next;

    assign adv       = !ov_reg || out_ready;
    assign pop       = adv;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_degen = odg_reg;

    for (genvar j = 0; j < D; j++) begin : g_st
        logic               vin;
        logic [NORM_W-1:0]  nin;
        logic [ENTRIES-1:0] sin;
        logic               din;
        logic [REM_W-1:0]   rin [ENTRIES];
        logic [QW-1:0]      qin [ENTRIES];
        if (j == 0) begin : g_head
            assign vin = !stat.empty;
            assign nin = head.norm;
            assign sin = head.sgn;
            assign din = head.degen;
            for (genvar l = 0; l < ENTRIES; l++) begin : g_l
                assign rin[l] = REM_W'(head.mag[l]);
                assign qin[l] = '0;
            end
        end else begin : g_prev
            assign vin = v_reg[j-1];
            assign nin = n_reg[j-1];
            assign sin = sgn_reg[j-1];
            assign din = dg_reg[j-1];
            for (genvar l = 0; l < ENTRIES; l++) begin : g_l
                assign rin[l] = {rem_reg[j-1][l][REM_W-2:0], 1'b0};
                assign qin[l] = quo_reg[j-1][l];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (adv) begin
                v_reg[j] <= vin;
            end
        end
        for (genvar l = 0; l < ENTRIES; l++) begin : g_div
            logic ge;
            assign ge = (rin[l] >= REM_W'(nin));
            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[j][l] <= ge ? rin[l] - REM_W'(nin) : rin[l];
                    quo_reg[j][l] <= {qin[l][QW-2:0], ge};
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                n_reg[j]   <= nin;
                sgn_reg[j] <= sin;
                dg_reg[j]  <= din;
            end
        end
    end

    always_comb begin
        logic [QW:0]     qp;
        logic [QW-1:0]   r;
        logic signed [SW-1:0] sv;
        for (int l = 0; l < ENTRIES; l++) begin
            qp = {1'b0, quo_reg[D-1][l]} + 1'b1;
            r  = qp[QW:1];
            if (r > (QW'(1) << FRAC_BITS)) r = QW'(1) << FRAC_BITS;
            if (dg_reg[D-1]) begin
                r = (l == 0 || l == 4 || l == 8) ? (QW'(1) << FRAC_BITS) : '0;
            end
            sv = SW'(r);
            if (sgn_reg[D-1][l] && !dg_reg[D-1]) sv = -sv;
            if (sv > SW'(32767)) sv = SW'(32767);
            if (sv < -SW'(32768)) sv = -SW'(32768);
            od_next[l*16 +: 16] = sv[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (adv) begin
            ov_reg <= v_reg[D-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            od_reg  <= od_next;
            odg_reg <= dg_reg[D-1];
        end
    end

endmodule

>>> tb/tb.sv
// Testbench for quaternion_to_rotation_matrix_unit.
// Drives quaternions over the s_ stream, predicts the nine rotation entries
// and the degenerate flag, and checks every m_ transaction; needs only the RTL.
`timescale 1ns / 100ps

module tb;

    localparam int FB     = 14;
    localparam int LAT    = FB + 6;
    localparam int N_RAND = 650;

    typedef struct packed {
        logic [143:0] mat;
        logic         degen;
    } rot_t;

    typedef struct packed {
        logic [63:0] q;
        logic        chk;
        rot_t        exp;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         m_tuser;

    rot_t         rot_q[$];
    int           errors;
    logic         hold_long;

    quaternion_to_rotation_matrix_unit #(.FRAC_BITS(FB)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic logic [15:0] round_entry(longint num, longint den);
        longint mag;
        longint r;
        mag = (num < 0) ? -num : num;
        r = ((mag <<< (FB + 1)) + den) / (den * 2);
        if (r > (64'sd1 <<< FB))
            r = 64'sd1 <<< FB;
        if (num < 0)
            r = -r;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic rot_t rotation_of(logic [63:0] q);
        longint x, y, z, w, xx, yy, zz, n;
        logic [15:0] one;
        rot_t res;
        x = longint'($signed(q[15:0]));
        y = longint'($signed(q[31:16]));
        z = longint'($signed(q[47:32]));
        w = longint'($signed(q[63:48]));
        xx = x * x;
        yy = y * y;
        zz = z * z;
        n = xx + yy + zz + w * w;
        res = '0;
        if (n == 0) begin
            one = round_entry(1, 1);
            res.mat[15:0]    = one;
            res.mat[79:64]   = one;
            res.mat[143:128] = one;
            res.degen        = 1'b1;
        end else begin
            res.mat[15:0]    = round_entry(n - 2 * yy - 2 * zz, n);
            res.mat[31:16]   = round_entry(2 * x * y + 2 * z * w, n);
            res.mat[47:32]   = round_entry(2 * x * z - 2 * y * w, n);
            res.mat[63:48]   = round_entry(2 * x * y - 2 * z * w, n);
            res.mat[79:64]   = round_entry(n - 2 * xx - 2 * zz, n);
            res.mat[95:80]   = round_entry(2 * y * z + 2 * x * w, n);
            res.mat[111:96]  = round_entry(2 * x * z + 2 * y * w, n);
            res.mat[127:112] = round_entry(2 * y * z - 2 * x * w, n);
            res.mat[143:128] = round_entry(n - 2 * xx - 2 * yy, n);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [143:0] got, logic [143:0] exp);
        $display("ERROR %0t: %s got %h exp %h", $time, what, got, exp);
        errors++;
    endtask

    task automatic send_quat(logic [63:0] q, rot_t exp);
        s_tdata  <= q;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        rot_q.push_back(exp);
        @(negedge aclk);
    endtask

    task automatic idle_sender(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 16)) - 16'd8;
            4: return 16'h4000;
            default: return 16'($urandom());
        endcase
    endfunction

    // directed rows: quaternion, check flag, expected (typed only where obvious)
    dir_row_t dir_rows[] = '{
        {64'h0000_0000_0000_0000, 1'b1,
         144'h4000_0000_0000_0000_4000_0000_0000_0000_4000, 1'b1},
        {64'h4000_0000_0000_0000, 1'b1,
         144'h4000_0000_0000_0000_4000_0000_0000_0000_4000, 1'b0},
        {64'hc000_0000_0000_0000, 1'b1,
         144'h4000_0000_0000_0000_4000_0000_0000_0000_4000, 1'b0},
        {64'h0000_0000_0000_4000, 1'b1,
         144'hc000_0000_0000_0000_c000_0000_0000_0000_4000, 1'b0},
        {64'h0000_0000_4000_0000, 1'b1,
         144'hc000_0000_0000_0000_4000_0000_0000_0000_c000, 1'b0},
        {64'h0000_4000_0000_0000, 1'b1,
         144'h4000_0000_0000_0000_c000_0000_0000_0000_c000, 1'b0},
        {64'h8000_8000_8000_8000, 1'b1,
         144'h0000_0000_4000_4000_0000_0000_0000_4000_0000, 1'b0},
        {64'h7fff_7fff_7fff_7fff, 1'b0, 145'd0},
        {64'h7fff_8000_7fff_8000, 1'b0, 145'd0},
        {64'h0001_0000_0000_0000, 1'b0, 145'd0},
        {64'h0000_0000_0000_0001, 1'b0, 145'd0},
        {64'hffff_ffff_ffff_ffff, 1'b0, 145'd0},
        {64'h0001_0001_0001_0001, 1'b0, 145'd0},
        {64'h2d41_0000_0000_2d41, 1'b0, 145'd0},
        {64'h2000_2000_2000_2000, 1'b0, 145'd0},
        {64'h8000_0000_0000_0000, 1'b0, 145'd0},
        {64'h0000_7fff_8000_0001, 1'b0, 145'd0},
        {64'h5555_aaaa_5555_aaaa, 1'b0, 145'd0},
        {64'h0003_0001_0002_0001, 1'b0, 145'd0}
    };

    initial begin
        int k, burst;
        logic [63:0] qr;
        errors    = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        foreach (dir_rows[i])
            send_quat(dir_rows[i].q,
                      dir_rows[i].chk ? dir_rows[i].exp : rotation_of(dir_rows[i].q));
        idle_sender(1);
        wait (rot_q.size() == 0);
        @(negedge aclk);
        k = 0;
        while (k < N_RAND) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                qr = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
                send_quat(qr, rotation_of(qr));
                k++;
            end
            if (k > 300 && k < 340) begin
                idle_sender(1);
                wait (rot_q.size() == 0);
                @(negedge aclk);
            end else if ($urandom_range(0, 2) == 0) begin
                idle_sender($urandom_range(1, 6));
            end
        end
        s_tvalid <= 1'b0;
        wait (rot_q.size() == 0);
        repeat (LAT + 4) @(posedge aclk);
        if (errors == 0)
            $display("quaternion_to_rotation_matrix_unit: match");
        else
            $display("quaternion_to_rotation_matrix_unit: mismatch");
        $finish;
    end

    initial begin
        hold_long = 1'b0;
        wait (aresetn);
        repeat (200) @(negedge aclk);
        hold_long = 1'b1;
        repeat (120) @(negedge aclk);
        hold_long = 1'b0;
    end

    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else if (hold_long)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 9) < 7) || (($time / 2000) % 3 == 0);
    end

    always @(posedge aclk) begin
        rot_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            if (rot_q.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata, '0);
            end else begin
                exp = rot_q.pop_front();
                for (int e = 0; e < 9; e++)
                    if (m_tdata[e*16 +: 16] !== exp.mat[e*16 +: 16])
                        report_mismatch($sformatf("entry %0d", e),
                                        144'(m_tdata[e*16 +: 16]),
                                        144'(exp.mat[e*16 +: 16]));
                if (m_tuser !== exp.degen)
                    report_mismatch("degenerate", 144'(m_tuser), 144'(exp.degen));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("quaternion_to_rotation_matrix_unit: mismatch");
        $finish;
    end

endmodule
